### sv/fcr_pkg.sv
// Shared constants and codes for the FIFO cache replacement block.
// No dependencies; fcr_if, fcr_scan and the top level import this package.
package fcr_pkg;

  // Field widths fixed by the word format
  localparam int LINE_W = 6;
  localparam int SET_W  = 6;
  localparam int VICT_W = 6;
  localparam int WAYS_W = 3;

  // Reset value of the ways_log2 register
  localparam logic [WAYS_W-1:0] WAYS_RST = 3'd2;

  // Request kinds
  localparam logic KIND_FILL   = 1'b0;
  localparam logic KIND_CHOOSE = 1'b1;

  // Default sizes handed down from the top level
  localparam int NUM_LINES_DEF = 64;
  localparam int AGE_BITS_DEF  = 16;

endpackage

### sv/fcr_if.sv
// Valid/ready channel interfaces for request and result words.
// Depends on fcr_pkg for field widths.
interface fcr_in_if;
  import fcr_pkg::*;
  logic              valid;
  logic              ready;
  logic              kind;
  logic [LINE_W-1:0] line_index;
  logic [SET_W-1:0]  set_index;
  modport source (output valid, kind, line_index, set_index, input ready);
  modport sink   (input valid, kind, line_index, set_index, output ready);
endinterface

interface fcr_out_if;
  import fcr_pkg::*;
  logic              valid;
  logic              ready;
  logic [VICT_W-1:0] victim_line;
  logic              was_fill;
  modport source (output valid, victim_line, was_fill, input ready);
  modport sink   (input valid, victim_line, was_fill, output ready);
endinterface

### sv/fcr_age_mem.sv
// Line state memory: one {valid, age} entry per cache line.
// One write port, one read port with registered read data; no dependencies.
module fcr_age_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int DW    = 17
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sv/fcr_scan.sv
// Sequencer for the replacement block: clears line state after reset, then
// walks one set per request, aging lines on a fill or picking the oldest line.
// Depends on fcr_pkg and fcr_age_mem.
module fcr_scan #(
  parameter int NUM_LINES = fcr_pkg::NUM_LINES_DEF,
  parameter int AGE_BITS  = fcr_pkg::AGE_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [fcr_pkg::WAYS_W-1:0]  ways_log2,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_kind,
  input  logic [fcr_pkg::LINE_W-1:0]  in_line,
  input  logic [fcr_pkg::SET_W-1:0]   in_set,
  output logic                        res_valid,
  input  logic                        res_ready,
  output logic [fcr_pkg::VICT_W-1:0]  res_victim,
  output logic                        res_fill
);
  import fcr_pkg::*;

  localparam int IDX_W = $clog2(NUM_LINES);
  localparam int CNT_W = IDX_W + 1;
  localparam int MW    = IDX_W + 8;
  localparam int DW    = AGE_BITS + 1;

  localparam logic [1:0] ST_CLR  = 2'd0;
  localparam logic [1:0] ST_IDLE = 2'd1;
  localparam logic [1:0] ST_RUN  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0]          state_r, state_nxt;
  logic [CNT_W-1:0]    k_r, k_nxt;
  logic [CNT_W-1:0]    end_r, end_nxt;
  logic [CNT_W-1:0]    line_r, line_nxt;
  logic                kind_r, kind_nxt;
  logic [IDX_W-1:0]    pk_r, pk_nxt;
  logic                rdv_r, rdv_nxt;
  logic [CNT_W-1:0]    best_r, best_nxt;
  logic [AGE_BITS-1:0] best_age_r, best_age_nxt;

  logic                mem_we, mem_re;
  logic [IDX_W-1:0]    mem_waddr, mem_raddr;
  logic [DW-1:0]       mem_wdata, mem_rdata;
  logic                rd_line_valid;
  logic [AGE_BITS-1:0] rd_age;

  logic [MW-1:0] w_ext, span, line_ext, set_ext, fill_base, choose_base;
  logic [MW-1:0] base, end_raw, end_clip, best_ext;
  logic          full, skip;

  fcr_age_mem #(
    .DEPTH (NUM_LINES),
    .AW    (IDX_W),
    .DW    (DW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign rd_line_valid = mem_rdata[DW-1];
  assign rd_age        = mem_rdata[AGE_BITS-1:0];

  // Set bounds for the incoming request
  always_comb begin
    w_ext       = MW'(ways_log2);
    full        = (w_ext >= MW'(IDX_W));
    span        = full ? MW'(NUM_LINES) : (MW'(1) << ways_log2);
    line_ext    = MW'(in_line);
    set_ext     = MW'(in_set);
    fill_base   = full ? '0 : ((line_ext >> ways_log2) << ways_log2);
    choose_base = full ? '0 : (set_ext << ways_log2);
    base        = (in_kind == KIND_FILL) ? fill_base : choose_base;
    end_raw     = base + span;
    end_clip    = (end_raw > MW'(NUM_LINES)) ? MW'(NUM_LINES) : end_raw;
    skip        = (in_kind == KIND_FILL) ? (line_ext >= MW'(NUM_LINES))
                                         : (base >= MW'(NUM_LINES));
  end

  // Result fields
  assign best_ext   = MW'(best_r);
  assign res_fill   = (kind_r == KIND_FILL);
  assign res_victim = res_fill ? '0 : best_ext[VICT_W-1:0];

  // Sequencer
  always_comb begin
    state_nxt    = state_r;
    k_nxt        = k_r;
    end_nxt      = end_r;
    line_nxt     = line_r;
    kind_nxt     = kind_r;
    pk_nxt       = pk_r;
    rdv_nxt      = rdv_r;
    best_nxt     = best_r;
    best_age_nxt = best_age_r;
    mem_we       = 1'b0;
    mem_waddr    = pk_r;
    mem_wdata    = '0;
    mem_re       = 1'b0;
    mem_raddr    = k_r[IDX_W-1:0];
    in_ready     = 1'b0;
    res_valid    = 1'b0;
    unique case (state_r)
      ST_CLR: begin
        // sweep every entry to zero age, not valid
        mem_we    = 1'b1;
        mem_waddr = k_r[IDX_W-1:0];
        if (k_r == CNT_W'(NUM_LINES - 1)) begin
          k_nxt     = '0;
          state_nxt = ST_IDLE;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          kind_nxt     = in_kind;
          line_nxt     = CNT_W'(line_ext);
          k_nxt        = CNT_W'(base);
          end_nxt      = CNT_W'(end_clip);
          best_nxt     = skip ? '0 : CNT_W'(base);
          best_age_nxt = '0;
          rdv_nxt      = 1'b0;
          state_nxt    = skip ? ST_FIN : ST_RUN;
        end
      end
      ST_RUN: begin
        // issue the next read of the set
        if (k_r < end_r) begin
          mem_re  = 1'b1;
          rdv_nxt = 1'b1;
          pk_nxt  = k_r[IDX_W-1:0];
          k_nxt   = k_r + 1'b1;
        end else begin
          rdv_nxt = 1'b0;
        end
        // age (fill) or compare (choose) the entry read last cycle
        if (rdv_r) begin
          if (kind_r == KIND_FILL) begin
            if (pk_r == line_r[IDX_W-1:0]) begin
              mem_we    = 1'b1;
              mem_wdata = {1'b1, {AGE_BITS{1'b0}}};
            end else if (rd_line_valid && (rd_age != {AGE_BITS{1'b1}})) begin
              mem_we    = 1'b1;
              mem_wdata = {1'b1, rd_age + 1'b1};
            end
          end else if (rd_age >= best_age_r) begin
            best_age_nxt = rd_age;
            best_nxt     = {1'b0, pk_r};
          end
        end
        if ((k_r >= end_r) && !rdv_r) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        // hold the result until the output register takes it
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLR;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR;
      k_r     <= '0;
      rdv_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      rdv_r   <= rdv_nxt;
    end
  end

  // Work registers
  always_ff @(posedge clk) begin
    end_r      <= end_nxt;
    line_r     <= line_nxt;
    kind_r     <= kind_nxt;
    pk_r       <= pk_nxt;
    best_r     <= best_nxt;
    best_age_r <= best_age_nxt;
  end

endmodule

### sv/fifo_cache_replacement.sv
// FIFO cache replacement. A fill or victim search reads every line entry of its set, one
// per cycle. An out-of-range fill or set reads no entries and gives its result directly.
// Results go through an output register, so a new word is taken while the last result
// waits. After reset the line memory is cleared before the first word is accepted;
// ways_log2 resets to 2.
module fifo_cache_replacement #(
  parameter int NUM_LINES = fcr_pkg::NUM_LINES_DEF,
  parameter int AGE_BITS  = fcr_pkg::AGE_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [fcr_pkg::WAYS_W-1:0]  cfg_wdata,
  fcr_in_if.sink                      in_ch,
  fcr_out_if.source                   out_ch
);
  import fcr_pkg::*;

  logic [WAYS_W-1:0] ways_r;
  logic              res_valid, res_ready, res_fill;
  logic [VICT_W-1:0] res_victim;
  logic              out_valid_r;
  logic [VICT_W-1:0] victim_r;
  logic              fill_r;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ways_r <= WAYS_RST;
    end else if (cfg_we) begin
      ways_r <= cfg_wdata;
    end
  end

  fcr_scan #(
    .NUM_LINES (NUM_LINES),
    .AGE_BITS  (AGE_BITS)
  ) u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .ways_log2  (ways_r),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_kind    (in_ch.kind),
    .in_line    (in_ch.line_index),
    .in_set     (in_ch.set_index),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res_victim (res_victim),
    .res_fill   (res_fill)
  );

  // Output register: load when empty or draining
  assign res_ready = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      victim_r <= res_victim;
      fill_r   <= res_fill;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.victim_line = victim_r;
  assign out_ch.was_fill    = fill_r;

endmodule
